// ----- hw/rtl/xor_nearest_key_table_defines.svh -----
// Assertion macros for the XOR nearest key table checker.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef XOR_NEAREST_KEY_TABLE_DEFINES_SVH
`define XOR_NEAREST_KEY_TABLE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define XNKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define XNKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/xnkt_pkg.sv -----
// Shared types and constants for the XOR nearest key table.
// No dependencies; used by the controller, datapath, top level and checker.
package xnkt_pkg;

  // Port field width and default table geometry
  localparam int FIELD_BITS     = 64;
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_VALUE_BITS  = 64;

  // Operation codes on func
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_CLOSEST  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write an empty row at the sweep address
    logic load;    // capture an input word and restart the scan
    logic rd;      // read the row at the scan address
    logic commit;  // apply the table update and load the result
  } xnkt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic addr_last;  // sweep address is on the last row
    logic out_free;   // result register can take a new word
  } xnkt_stat_t;

endpackage

// ----- hw/rtl/xor_nearest_key_table.sv -----
// Top level of the XOR nearest key table: controller plus datapath.
// Depends on xnkt_pkg, xnkt_ctrl and xnkt_dp.
//
//   channel | handshake          | fields
//   --------+--------------------+--------------------------------------------
//   in      | in_valid, in_stall | func, key_in, value_in
//   out     | out_valid, out_stall| status, hit, found_key, found_value,
//           |                    | found_distance
//
// Each word is taken in idle, then scanned with one memory read per row over
// the whole table, drained for the last read and committed. The next word
// can be taken in the cycle after the commit; the block holds one word at a
// time, since every word needs a full pass over the single memory read port.
// After reset the table runs a clearing pass over every row with in_stall
// high. A stalled result holds the next word in commit until the result
// register frees; a new word is taken while a result waits.
module xor_nearest_key_table #(
  parameter int TABLE_DEPTH = xnkt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = xnkt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = xnkt_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [xnkt_pkg::FIELD_BITS-1:0] key_in,
  input  logic [xnkt_pkg::FIELD_BITS-1:0] value_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic                            hit,
  output logic [xnkt_pkg::FIELD_BITS-1:0] found_key,
  output logic [xnkt_pkg::FIELD_BITS-1:0] found_value,
  output logic [xnkt_pkg::FIELD_BITS-1:0] found_distance
);
  import xnkt_pkg::*;

  xnkt_cmd_t  cmd;
  xnkt_stat_t stat;

  // Sequence the scan
  xnkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store rows, compare and hold the result
  xnkt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .key_in         (key_in),
    .value_in       (value_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .hit            (hit),
    .found_key      (found_key),
    .found_value    (found_value),
    .found_distance (found_distance)
  );

endmodule

// ----- hw/rtl/xnkt_ctrl.sv -----
// Controller state machine for the XOR nearest key table.
// Depends on xnkt_pkg for the command and status structs.
module xnkt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  xnkt_pkg::xnkt_stat_t   stat,
  output xnkt_pkg::xnkt_cmd_t    cmd
);
  import xnkt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands from the current state
  always_comb begin
    cmd        = '0;
    cmd.clear  = (state == S_CLEAR);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.rd     = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT) && stat.out_free;
  end

  // Sequence: clear sweep, wait for a word, scan all rows, drain, commit
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.addr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.addr_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Hold state and the registered input stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_stall <= 1'b1;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- hw/rtl/xnkt_dp.sv -----
// Datapath for the XOR nearest key table: row memory, scan registers and
// result register. Depends on xnkt_pkg; driven by xnkt_ctrl commands.
module xnkt_dp #(
  parameter int TABLE_DEPTH = xnkt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = xnkt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = xnkt_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  xnkt_pkg::xnkt_cmd_t             cmd,
  output xnkt_pkg::xnkt_stat_t            stat,
  input  logic [1:0]                      func,
  input  logic [xnkt_pkg::FIELD_BITS-1:0] key_in,
  input  logic [xnkt_pkg::FIELD_BITS-1:0] value_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic                            hit,
  output logic [xnkt_pkg::FIELD_BITS-1:0] found_key,
  output logic [xnkt_pkg::FIELD_BITS-1:0] found_value,
  output logic [xnkt_pkg::FIELD_BITS-1:0] found_distance
);
  import xnkt_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int ROW_BITS = 1 + KEY_BITS + VALUE_BITS;

  // Row memory: {live, key, value}
  logic [ROW_BITS-1:0] mem [TABLE_DEPTH];
  logic [ROW_BITS-1:0] rdata;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [ROW_BITS-1:0] wdata;

  logic [AW-1:0]         addr;
  logic                  addr_last;
  logic [AW-1:0]         rd_idx;
  logic                  rvalid;

  logic [1:0]            op;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  found;
  logic [AW-1:0]         best_idx;
  logic [KEY_BITS-1:0]   best_key;
  logic [VALUE_BITS-1:0] best_val;
  logic [KEY_BITS-1:0]   best_dist;
  logic                  dup;
  logic                  free_found;
  logic [AW-1:0]         free_idx;

  logic                  row_live;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_val;
  logic [KEY_BITS-1:0]   row_dist;
  logic                  key_eq;
  logic                  cand;
  logic                  better;

  logic [1:0]            res_status;
  logic                  res_hit;
  logic [FIELD_BITS-1:0] res_key;
  logic [FIELD_BITS-1:0] res_val;
  logic [FIELD_BITS-1:0] res_dist;

  assign addr_last      = (addr == AW'(TABLE_DEPTH - 1));
  assign stat.addr_last = addr_last;
  assign stat.out_free  = !out_valid || !out_stall;

  // Advance the sweep address for clearing and scanning
  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= cmd.rd;
      if (cmd.load) begin
        addr <= '0;
      end else if (cmd.clear || cmd.rd) begin
        addr <= addr_last ? '0 : addr + AW'(1);
      end
    end
  end

  // Write one row and read one row per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) begin
      rdata  <= mem[addr];
      rd_idx <= addr;
    end
  end

  // Split the row that came back and compare it with the search word
  assign row_live = rdata[ROW_BITS-1];
  assign r_key    = rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign r_val    = rdata[VALUE_BITS-1:0];
  assign row_dist = r_key ^ key_q;
  assign key_eq   = (r_key == key_q);
  assign cand     = row_live && (op != OP_INSERT) && ((op == OP_CLOSEST) || key_eq);
  assign better   = !found || (row_dist < best_dist) ||
                    ((row_dist == best_dist) && (r_val < best_val));

  // Capture the word, then fold each row into the running best, the duplicate flag and the first free row
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= func;
      key_q      <= key_in[KEY_BITS-1:0];
      val_q      <= value_in[VALUE_BITS-1:0];
      found      <= 1'b0;
      dup        <= 1'b0;
      free_found <= 1'b0;
    end else if (rvalid) begin
      if (cand && better) begin
        found     <= 1'b1;
        best_idx  <= rd_idx;
        best_key  <= r_key;
        best_val  <= r_val;
        best_dist <= row_dist;
      end
      if ((op == OP_INSERT) && row_live && key_eq && (r_val == val_q)) begin
        dup <= 1'b1;
      end
      if ((op == OP_INSERT) && !row_live && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end

  // Select the memory write: empty row on clear, insert or drop on commit
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      case (op)
        OP_INSERT: begin
          if (!dup && free_found) begin
            we    = 1'b1;
            waddr = free_idx;
            wdata = {1'b1, key_q, val_q};
          end
        end
        OP_DELETE: begin
          if (found) begin
            we    = 1'b1;
            waddr = best_idx;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // Form the result word
  always_comb begin
    res_status = ST_OK;
    res_hit    = 1'b0;
    res_key    = '0;
    res_val    = '0;
    res_dist   = '0;
    case (op)
      OP_INSERT: begin
        if (!dup && !free_found) res_status = ST_FULL;
      end
      OP_DELETE, OP_CONTAINS: begin
        if (found) res_hit = 1'b1;
        else res_status = ST_MISS;
      end
      OP_CLOSEST: begin
        if (found) begin
          res_hit  = 1'b1;
          res_key  = FIELD_BITS'(best_key);
          res_val  = FIELD_BITS'(best_val);
          res_dist = FIELD_BITS'(best_dist);
        end else begin
          res_status = ST_MISS;
        end
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  // Hold the result until the output side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= res_status;
      hit            <= res_hit;
      found_key      <= res_key;
      found_value    <= res_val;
      found_distance <= res_dist;
    end
  end

endmodule

// ----- hw/rtl/xnkt_checker.sv -----
// Port checker for the XOR nearest key table, bound to the top level.
// Depends on xnkt_pkg and xor_nearest_key_table_defines.svh.
`include "xor_nearest_key_table_defines.svh"

module xnkt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      status,
  input logic                            hit,
  input logic [xnkt_pkg::FIELD_BITS-1:0] found_key,
  input logic [xnkt_pkg::FIELD_BITS-1:0] found_value,
  input logic [xnkt_pkg::FIELD_BITS-1:0] found_distance
);
  import xnkt_pkg::*;

  // A stalled result word holds
  `XNKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(hit) && $stable(found_key) && $stable(found_value) && $stable(found_distance), "stalled result changed")

  // A hit always reports success
  `XNKT_ASSERT_NOW(a_hit_ok, out_valid && hit, status == ST_OK, "hit without ok status")

  // Without a hit the found fields are zero
  `XNKT_ASSERT_NOW(a_miss_zero, out_valid && !hit, found_key == '0 && found_value == '0 && found_distance == '0, "found fields set without hit")

  // One word at a time: the block is busy right after it takes a word
  `XNKT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken during a scan")

endmodule

bind xor_nearest_key_table xnkt_checker u_chk (.*);

// ----- test/xor_nearest_key_table_test.sv -----
// Self-checking testbench for xor_nearest_key_table: directed table, then random words.
// Depends on xnkt_pkg and the xor_nearest_key_table RTL; needs no files or arguments.
module xor_nearest_key_table_test;
  import xnkt_pkg::*;

  localparam int DEPTH        = DEF_TABLE_DEPTH;
  localparam int RANDOM_WORDS = 1600;
  localparam int DRAIN_CYCLES = DEPTH + 3 + 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 12;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] fkey;
    logic [63:0] fvalue;
    logic [63:0] fdist;
  } lookup_result_t;

  typedef struct {
    logic [1:0]     op;
    logic [63:0]    key;
    logic [63:0]    value;
    bit             known;
    lookup_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = OP_INSERT;
  logic [63:0] key_in = '0;
  logic [63:0] value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        hit;
  logic [63:0] found_key;
  logic [63:0] found_value;
  logic [63:0] found_distance;

  // Shadow copy of the table
  logic [63:0] ent_key [DEPTH];
  logic [63:0] ent_value [DEPTH];
  bit          ent_live [DEPTH];

  lookup_result_t due_results[$];
  stim_row_t      directed_rows[$];
  logic [63:0]    key_pool [POOL_SIZE];

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 33;
  int recv_stall_pct = 64;
  int op_count [4];
  int full_count = 0;
  int nearest_hits = 0;

  xor_nearest_key_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .key_in(key_in), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .hit(hit), .found_key(found_key),
    .found_value(found_value), .found_distance(found_distance)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow table and return its result
  function automatic lookup_result_t apply_table_op(logic [1:0] op, logic [63:0] key,
                                                    logic [63:0] value);
    lookup_result_t r;
    int free_slot;
    int best;
    bit dup;
    logic [63:0] bdist;
    logic [63:0] d;
    r = '0;
    r.status = ST_OK;
    free_slot = -1;
    best = -1;
    dup = 0;
    bdist = '0;
    case (op)
      OP_INSERT: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (ent_live[i]) begin
            if (ent_key[i] == key && ent_value[i] == value) dup = 1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (!dup) begin
          if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            ent_key[free_slot] = key;
            ent_value[free_slot] = value;
            ent_live[free_slot] = 1;
          end
        end
      end
      OP_DELETE, OP_CONTAINS: begin
        // pick the entry with this key and the smallest value
        for (int i = 0; i < DEPTH; i++) begin
          if (ent_live[i] && ent_key[i] == key &&
              (best < 0 || ent_value[i] < ent_value[best])) best = i;
        end
        if (best < 0) begin
          r.status = ST_MISS;
        end else begin
          r.hit = 1'b1;
          if (op == OP_DELETE) ent_live[best] = 0;
        end
      end
      default: begin
        // nearest by XOR distance, ties to the smaller value; all-ones distance counts
        for (int i = 0; i < DEPTH; i++) begin
          if (ent_live[i]) begin
            d = ent_key[i] ^ key;
            if (best < 0 || d < bdist || (d == bdist && ent_value[i] < ent_value[best])) begin
              best = i;
              bdist = d;
            end
          end
        end
        if (best < 0) begin
          r.status = ST_MISS;
        end else begin
          r.hit = 1'b1;
          r.fkey = ent_key[best];
          r.fvalue = ent_value[best];
          r.fdist = bdist;
        end
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t plain_row(logic [1:0] op, logic [63:0] key, logic [63:0] value);
    stim_row_t row;
    row.op = op;
    row.key = key;
    row.value = value;
    row.known = 0;
    row.res = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [1:0] op, logic [63:0] key, logic [63:0] value,
                                          logic [1:0] st, logic h, logic [63:0] fk,
                                          logic [63:0] fv, logic [63:0] fd);
    stim_row_t row;
    row = plain_row(op, key, value);
    row.known = 1;
    row.res.status = st;
    row.res.hit = h;
    row.res.fkey = fk;
    row.res.fvalue = fv;
    row.res.fdist = fd;
    return row;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Append one row to the directed table
  task automatic add_row(stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, what, got, want);
    errors++;
  endtask

  // Present one word, hold it until taken, then record its expected result
  task automatic issue_word(stim_row_t row);
    lookup_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= row.op;
    key_in <= row.key;
    value_in <= row.value;
    do @(posedge clk); while (in_stall);
    r = apply_table_op(row.op, row.key, row.value);
    if (row.known) r = row.res;
    due_results.insert(due_results.size(), r);
    op_count[row.op]++;
    if (r.status == ST_FULL) full_count++;
    if (row.op == OP_CLOSEST && r.hit) nearest_hits++;
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, due_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check each accepted result against the oldest expectation; drive stall
  always @(posedge clk) begin
    lookup_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing pending", found_key, '0);
      end else begin
        e = due_results.pop_front();
        if (status !== e.status) report_mismatch("status", 64'(status), 64'(e.status));
        if (hit !== e.hit) report_mismatch("hit", 64'(hit), 64'(e.hit));
        if (found_key !== e.fkey) report_mismatch("found_key", found_key, e.fkey);
        if (found_value !== e.fvalue) report_mismatch("found_value", found_value, e.fvalue);
        if (found_distance !== e.fdist)
          report_mismatch("found_distance", found_distance, e.fdist);
      end
    end
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    stim_row_t row;
    int total;
    int ins_pct;
    int pick;
    logic [1:0] op;
    logic [63:0] key;
    logic [63:0] value;

    for (int i = 0; i < DEPTH; i++) begin
      ent_key[i] = '0;
      ent_value[i] = '0;
      ent_live[i] = 0;
    end
    for (int i = 0; i < 4; i++) op_count[i] = 0;

    // Directed rows: empty table, duplicates, ties, extremes, back to empty
    add_row(known_row(OP_CLOSEST, ALL_ONES, ALL_ONES, ST_MISS, 1'b0, '0, '0, '0));
    add_row(known_row(OP_CONTAINS, '0, '0, ST_MISS, 1'b0, '0, '0, '0));
    add_row(known_row(OP_DELETE, ALL_ONES, '0, ST_MISS, 1'b0, '0, '0, '0));
    add_row(known_row(OP_INSERT, '0, '0, ST_OK, 1'b0, '0, '0, '0));
    add_row(known_row(OP_INSERT, '0, '0, ST_OK, 1'b0, '0, '0, '0));
    add_row(known_row(OP_INSERT, '0, 64'd5, ST_OK, 1'b0, '0, '0, '0));
    add_row(known_row(OP_CONTAINS, '0, ALL_ONES, ST_OK, 1'b1, '0, '0, '0));
    add_row(known_row(OP_CLOSEST, ALL_ONES, '0, ST_OK, 1'b1, '0, '0, ALL_ONES));
    add_row(known_row(OP_INSERT, ALL_ONES, ALL_ONES, ST_OK, 1'b0, '0, '0, '0));
    add_row(known_row(OP_CLOSEST, '0, '0, ST_OK, 1'b1, '0, '0, '0));
    add_row(plain_row(OP_CLOSEST, TOP_BIT, '0));
    add_row(known_row(OP_DELETE, '0, '0, ST_OK, 1'b1, '0, '0, '0));
    add_row(known_row(OP_CLOSEST, '0, ALL_ONES, ST_OK, 1'b1, '0, 64'd5, '0));
    add_row(plain_row(OP_CLOSEST, 64'h0123_4567_89ab_cdef, '0));
    add_row(known_row(OP_INSERT, 64'h5555_5555_5555_5555,
                      64'haaaa_aaaa_aaaa_aaaa, ST_OK, 1'b0, '0, '0, '0));
    add_row(plain_row(OP_CLOSEST, 64'haaaa_aaaa_aaaa_aaaa, '0));
    add_row(known_row(OP_DELETE, '0, '0, ST_OK, 1'b1, '0, '0, '0));
    add_row(known_row(OP_CONTAINS, '0, '0, ST_MISS, 1'b0, '0, '0, '0));
    add_row(known_row(OP_DELETE, ALL_ONES, '0, ST_OK, 1'b1, '0, '0, '0));
    add_row(known_row(OP_DELETE, 64'h5555_5555_5555_5555, '0,
                      ST_OK, 1'b1, '0, '0, '0));
    add_row(known_row(OP_CLOSEST, '0, '0, ST_MISS, 1'b0, '0, '0, '0));

    total = directed_rows.size() + RANDOM_WORDS;
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand64();

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < total; n++) begin
      // Swap idling roles by thirds, last third runs flat out
      if (n < total / 3) begin
        send_idle_pct = 33;
        recv_stall_pct = 64;
      end else if (n < 2 * total / 3) begin
        send_idle_pct = 64;
        recv_stall_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      if (n < directed_rows.size()) begin
        row = directed_rows[n];
      end else begin
        // New segment: change the insert mix to fill and drain the table, and redraw random pool keys
        if ((n - directed_rows.size()) % 64 == 0) begin
          case ($urandom_range(2))
            0: ins_pct = 15;
            1: ins_pct = 45;
            default: ins_pct = 80;
          endcase
          for (int i = 2; i < POOL_SIZE; i++) begin
            if ($urandom_range(1) == 1) key_pool[i] = rand64();
          end
        end
        if ($urandom_range(99) < ins_pct) begin
          op = OP_INSERT;
        end else begin
          case ($urandom_range(2))
            0: op = OP_DELETE;
            1: op = OP_CONTAINS;
            default: op = OP_CLOSEST;
          endcase
        end
        pick = $urandom_range(99);
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick >= 85) key = rand64();
        else if (pick >= 60) key[$urandom_range(63)] = ~key[$urandom_range(63)];
        value = ($urandom_range(99) < 60) ? 64'($urandom_range(3)) : rand64();
        row = plain_row(op, key, value);
      end
      issue_word(row);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d insert, %0d delete, %0d contains, %0d closest",
             total, op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_CONTAINS],
             op_count[OP_CLOSEST]);
    $display("Table full seen %0d times, %0d nearest-key hits, %0d mismatches",
             full_count, nearest_hits, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
